// ===== design/hsfc_pkg.sv =====
`timescale 1ns / 1ps

package hsfc_pkg;

    typedef logic [1:0] t_path;

    // how stage two finishes a word
    localparam t_path PATH_FIXED    = 2'd0;   // result already complete
    localparam t_path PATH_H2S_SUB  = 2'd1;   // half subnormal, normalize
    localparam t_path PATH_S2H_NORM = 2'd2;   // single to half normal, round
    localparam t_path PATH_S2H_SUB  = 2'd3;   // single to half subnormal, shift and round

    localparam logic KIND_H2S = 1'b0;
    localparam logic KIND_S2H = 1'b1;

    localparam logic [14:0] HALF_QNAN      = 15'h7E00;
    localparam logic [14:0] HALF_INF       = 15'h7C00;
    localparam logic [30:0] SINGLE_INF     = 31'h7F80_0000;
    localparam logic [7:0]  BIAS_DIFF      = 8'd112;   // 127 - 15
    localparam logic [7:0]  H2S_SUB_EXP    = 8'd103;   // exponent of a half subnormal at bit 0
    localparam logic [7:0]  S2H_OVF_EXP    = 8'd143;   // half exponent 31 and above
    localparam logic [7:0]  S2H_SUB_MIN    = 8'd102;   // half exponent -10
    localparam logic [7:0]  S2H_SH_BASE    = 8'd126;   // shift = 126 - single exponent
    localparam logic [7:0]  SINGLE_EXP_MAX = 8'hFF;
    localparam logic [4:0]  HALF_EXP_MAX   = 5'h1F;
    localparam logic [4:0]  H2S_MANT_TOP   = 5'd23;

endpackage

// ===== design/half_single_float_convert.sv =====
`timescale 1ns / 1ps

// half <-> single precision bit-pattern converter
//
// input channel: i_in_valid / o_in_ready carry one word per transfer,
//   i_kind selects the direction (0 half to single, 1 single to half) and
//   i_value holds the source pattern (a half source sits in bits 15..0)
// output channel: o_out_valid / i_out_ready carry the converted pattern;
//   a half result sits in bits 15..0 with bits 31..16 zero
// single to half rounds to nearest, ties to even, with guard and sticky bits
//
// throughput: one word per cycle while the output is not stalled; the three
//   register stages (decode and classify, shift and round decision, round
//   increment) each take a new word in every cycle
// stall: when i_out_ready is low the output word holds; upstream stages keep
//   filling until all three are full, then o_in_ready drops; nothing is lost
//   or repeated
// reset: synchronous, active low; clears the stage valid bits only, the
//   block accepts words in the first cycle after reset
module half_single_float_convert
    import hsfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_converted
);

    // stage advance chain, each stage moves when it is empty or its
    // successor moves
    logic w_adv1, w_adv2, w_adv3;
    logic r_v1, r_v2, r_v3;

    assign w_adv3     = !r_v3 || i_out_ready;
    assign w_adv2     = !r_v2 || w_adv3;
    assign w_adv1     = !r_v1 || w_adv2;
    assign o_in_ready = w_adv1;
    assign o_out_valid = r_v3;

    // ---------------- stage 1: field split and classify ----------------
    logic        n_sign_h, n_sign_s;
    logic [4:0]  n_he;
    logic [9:0]  n_hm;
    logic [7:0]  n_se;
    logic [22:0] n_sm;
    logic [3:0]  n_lz;

    t_path       n_path;
    logic [31:0] n_fixed;
    logic        n_sign;
    logic [22:0] n_m;
    logic [4:0]  n_ex;
    logic [4:0]  n_sh;
    logic [7:0]  n_sh_full;
    logic [7:0]  n_ex_full;

    t_path       r_path;
    logic [31:0] r_fixed;
    logic        r_sign;
    logic [22:0] r_m;
    logic [4:0]  r_ex;
    logic [4:0]  r_sh;
    logic [3:0]  r_lz;

    assign n_sign_h  = i_value[15];
    assign n_he      = i_value[14:10];
    assign n_hm      = i_value[9:0];
    assign n_sign_s  = i_value[31];
    assign n_se      = i_value[30:23];
    assign n_sm      = i_value[22:0];
    assign n_ex_full = n_se - BIAS_DIFF;
    assign n_sh_full = S2H_SH_BASE - n_se;

    // leading one of the half mantissa, highest set bit wins
    always_comb begin
        n_lz = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (n_hm[i]) n_lz = 4'(i);
        end
    end

    always_comb begin
        n_path  = PATH_FIXED;
        n_fixed = 32'd0;
        n_sign  = n_sign_s;
        n_m     = n_sm;
        n_ex    = n_ex_full[4:0];
        n_sh    = n_sh_full[4:0];
        if (i_kind == KIND_H2S) begin
            n_sign = n_sign_h;
            n_m    = {13'd0, n_hm};
            if (n_he == 5'd0) begin
                if (n_hm == 10'd0) begin
                    n_fixed = {n_sign_h, 31'd0};
                end else begin
                    n_path = PATH_H2S_SUB;
                end
            end else if (n_he == HALF_EXP_MAX) begin
                n_fixed = {n_sign_h, SINGLE_INF | {8'd0, n_hm, 13'd0}};
            end else begin
                n_fixed = {n_sign_h, 8'({3'd0, n_he} + BIAS_DIFF), n_hm, 13'd0};
            end
        end else begin
            if (n_se == SINGLE_EXP_MAX) begin
                if (n_sm != 23'd0) begin
                    n_fixed = {16'd0, n_sign_s, HALF_QNAN | {5'd0, n_sm[22:13]}};
                end else begin
                    n_fixed = {16'd0, n_sign_s, HALF_INF};
                end
            end else if (n_se >= S2H_OVF_EXP) begin
                n_fixed = {16'd0, n_sign_s, HALF_INF};
            end else if (n_se > BIAS_DIFF) begin
                n_path = PATH_S2H_NORM;
            end else if (n_se >= S2H_SUB_MIN) begin
                n_path = PATH_S2H_SUB;
            end else begin
                // zero, single subnormal, or below half range
                n_fixed = {16'd0, n_sign_s, 15'd0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv1) begin
            r_v1 <= i_in_valid;
        end
        if (w_adv1) begin
            r_path  <= n_path;
            r_fixed <= n_fixed;
            r_sign  <= n_sign;
            r_m     <= n_m;
            r_ex    <= n_ex;
            r_sh    <= n_sh;
            r_lz    <= n_lz;
        end
    end

    // ---------------- stage 2: shift and round decision ----------------
    logic [4:0]  n_h2s_sh;
    logic [22:0] n_h2s_mant;
    logic [7:0]  n_h2s_exp;
    logic [23:0] n_sig;
    logic [23:0] n_kept24;
    logic [23:0] n_mask;
    logic [4:0]  n_gpos;
    logic        n_guard, n_sticky;
    logic [31:0] n_base;
    logic        n_inc;

    logic [31:0] r_base;
    logic        r_inc;

    assign n_h2s_sh   = H2S_MANT_TOP - {1'b0, r_lz};
    assign n_h2s_mant = {13'd0, r_m[9:0]} << n_h2s_sh;  // leading one drops off the top
    assign n_h2s_exp  = {4'd0, r_lz} + H2S_SUB_EXP;

    assign n_sig    = {1'b1, r_m};
    assign n_kept24 = n_sig >> r_sh;
    assign n_gpos   = r_sh - 5'd1;
    assign n_guard  = n_sig[n_gpos];
    assign n_mask   = ~({24{1'b1}} << n_gpos);
    assign n_sticky = |(n_sig & n_mask);

    always_comb begin
        n_base = r_fixed;
        n_inc  = 1'b0;
        unique case (r_path)
            PATH_FIXED: begin
                n_base = r_fixed;
            end
            PATH_H2S_SUB: begin
                n_base = {r_sign, n_h2s_exp, n_h2s_mant};
            end
            PATH_S2H_NORM: begin
                // carry out of the mantissa may reach infinity, which is right
                n_base = {16'd0, r_sign, r_ex, r_m[22:13]};
                n_inc  = r_m[12] && ((|r_m[11:0]) || r_m[13]);
            end
            PATH_S2H_SUB: begin
                // carry from kept 1023 lands on the smallest normal
                n_base = {16'd0, r_sign, 5'd0, n_kept24[9:0]};
                n_inc  = n_guard && (n_sticky || n_kept24[0]);
            end
            default: begin
                n_base = r_fixed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= r_v1;
        end
        if (w_adv2) begin
            r_base <= n_base;
            r_inc  <= n_inc;
        end
    end

    // ---------------- stage 3: round increment, output word ----------------
    logic [31:0] n_out;
    logic [31:0] r_out;

    assign n_out       = r_base + {31'd0, r_inc};
    assign o_converted = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv3) begin
            r_v3 <= r_v2;
        end
        if (w_adv3) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== design/hsfc_checker.sv =====
`timescale 1ns / 1ps

module hsfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_converted
);

    // a stalled word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_converted))
        else $error("output word changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // an empty output stage or a ready sink never backs up the input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled with room in the pipeline");

    // an accepted word reaches the output when the sink keeps i_out_ready high
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("word not delivered after three cycles");

endmodule

bind half_single_float_convert hsfc_checker u_hsfc_checker (.*);
